// ===== rtl/overloaded_rule_id_expander_unit_assert.svh =====
// Assertion macros for the overloaded rule-id expander.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef OVERLOADED_RULE_ID_EXPANDER_UNIT_ASSERT_SVH
`define OVERLOADED_RULE_ID_EXPANDER_UNIT_ASSERT_SVH

// same-cycle implication
`define ORIE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orie assertion failed");

// next-cycle implication
`define ORIE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orie assertion failed");

`endif

// ===== rtl/orie_pkg.sv =====
// Shared types and constants of the overloaded rule-id expander.
// No dependencies.
package orie_pkg;

	localparam int LANE_SLOTS = 4;
	localparam int LANE_SEL_W = 2;
	localparam int LANE_W = 16;
	localparam int ADDR_W = 12;
	localparam int CNT_W = 5;
	localparam int RULE_W = 15;
	localparam int OVERLOAD_BIT = 15;

	typedef enum logic [1:0] {
		OP_FLIT    = 2'd0,
		OP_IDX_WR  = 2'd1,
		OP_RULE_WR = 2'd2,
		OP_NOP     = 2'd3
	} orie_op_t;

	typedef logic [LANE_SLOTS-1:0][LANE_W-1:0] orie_lanes_t;

	typedef struct packed {
		orie_op_t                             op;
		orie_lanes_t                          pass;
		logic [LANE_SLOTS-1:0]                over;
		logic [LANE_SLOTS-1:0][ADDR_W-1:0]    idx;
		logic                                 eop;
		logic                                 hits;
		logic [ADDR_W-1:0]                    addr;
		logic [ADDR_W-1:0]                    offset;
		logic [CNT_W-1:0]                     count;
		logic [RULE_W-1:0]                    rule;
	} orie_cmd_t;

	typedef struct packed {
		orie_lanes_t lanes;
		logic        eop;
		logic        hits;
		logic        last;
	} orie_res_t;

endpackage

// ===== rtl/orie_fifo.sv =====
// Two-entry queue of items of any packed type.
// Depends on nothing but its type parameter.
module orie_fifo #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	T                 mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_ok);
			rd_q  <= rd_q + PW'(pop_ok);
			cnt_q <= cnt_q + (PW+1)'(push_ok) - (PW+1)'(pop_ok);
		end
	end

endmodule

// ===== rtl/orie_front.sv =====
// Front end: accepts requests, classifies lanes and reduces addresses modulo the
// table depths over two stages. Depends on orie_pkg.
module orie_front import orie_pkg::*; #(
	parameter int LANES       = 4,
	parameter int INDEX_DEPTH = 1024,
	parameter int LIST_DEPTH  = 4096,
	parameter int MAX_COUNT   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  orie_lanes_t       lanes,
	input  logic              end_of_packet,
	input  logic              hits_flag,
	input  logic [ADDR_W-1:0] write_address,
	input  logic [ADDR_W-1:0] write_offset,
	input  logic [CNT_W-1:0]  write_count,
	input  logic [RULE_W-1:0] write_rule,
	output logic              cmd_push,
	output orie_cmd_t         cmd,
	input  logic              cmd_full
);

	localparam int MOD_STEPS = 6;
	localparam int HI_S1 = 11;
	localparam int HI_S2 = 5;

	// partial restoring reduction: MOD_STEPS compare-subtract steps from shift hi down
	function automatic logic [LANE_W-1:0] mod_part(input logic [LANE_W-1:0] val,
			input int unsigned dvs, input int hi);
		logic [31:0] acc;
		logic [31:0] sub;
		acc = 32'(val);
		for (int i = 0; i < MOD_STEPS; i++) begin
			sub = 32'(dvs) << (hi - i);
			if (acc >= sub)
				acc = acc - sub;
		end
		return acc[LANE_W-1:0];
	endfunction

	orie_op_t                         op_in;
	logic                             accept;
	logic                             s1_ready;
	logic                             s2_ready;
	logic                             v_s1;
	logic                             v_s2;

	logic [LANE_SLOTS-1:0]            over_c;
	orie_lanes_t                      pass_c;
	logic [LANE_SLOTS-1:0][LANE_W-1:0] lrem_c;
	logic [LANE_W-1:0]                arem_c;
	logic [LANE_W-1:0]                orem_c;
	logic [CNT_W-1:0]                 cnt_c;
	logic [LANE_W-1:0]                lane_g;

	orie_op_t                         op_s1;
	logic [LANE_SLOTS-1:0]            over_s1;
	orie_lanes_t                      pass_s1;
	logic [LANE_SLOTS-1:0][LANE_W-1:0] lrem_s1;
	logic                             eop_s1;
	logic                             hits_s1;
	logic [LANE_W-1:0]                arem_s1;
	logic [LANE_W-1:0]                orem_s1;
	logic [CNT_W-1:0]                 cnt_s1;
	logic [RULE_W-1:0]                rule_s1;

	orie_cmd_t                        cmd_c;
	orie_cmd_t                        cmd_s2;
	logic [LANE_W-1:0]                lfin;
	logic [LANE_W-1:0]                afin;
	logic [LANE_W-1:0]                ofin;

	assign op_in    = orie_op_t'(opcode);
	assign s2_ready = !v_s2 || !cmd_full;
	assign s1_ready = !v_s1 || s2_ready;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;
	assign cmd_push = v_s2 && !cmd_full;
	assign cmd      = cmd_s2;

	always_comb begin
		lane_g = '0;
		for (int i = 0; i < LANE_SLOTS; i++) begin
			lane_g    = (i < LANES) ? lanes[i] : '0;
			over_c[i] = lane_g[OVERLOAD_BIT];
			pass_c[i] = over_c[i] ? '0 : lane_g;
			lrem_c[i] = mod_part({1'b0, lane_g[OVERLOAD_BIT-1:0]}, INDEX_DEPTH, HI_S1);
		end
		arem_c = mod_part(LANE_W'(write_address),
			(op_in == OP_IDX_WR) ? 32'(INDEX_DEPTH) : 32'(LIST_DEPTH), HI_S1);
		orem_c = mod_part(LANE_W'(write_offset), LIST_DEPTH, HI_S1);
		cnt_c  = (write_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : write_count;
	end

	always_comb begin
		lfin = '0;
		cmd_c = '0;
		cmd_c.op   = op_s1;
		cmd_c.pass = pass_s1;
		cmd_c.over = over_s1;
		cmd_c.eop  = eop_s1;
		cmd_c.hits = hits_s1;
		for (int i = 0; i < LANE_SLOTS; i++) begin
			lfin         = mod_part(lrem_s1[i], INDEX_DEPTH, HI_S2);
			cmd_c.idx[i] = lfin[ADDR_W-1:0];
		end
		afin = mod_part(arem_s1,
			(op_s1 == OP_IDX_WR) ? 32'(INDEX_DEPTH) : 32'(LIST_DEPTH), HI_S2);
		ofin = mod_part(orem_s1, LIST_DEPTH, HI_S2);
		cmd_c.addr   = afin[ADDR_W-1:0];
		cmd_c.offset = ofin[ADDR_W-1:0];
		cmd_c.count  = cnt_s1;
		cmd_c.rule   = rule_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				v_s1 <= accept && (op_in != OP_NOP);
			if (s2_ready)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_in;
			over_s1 <= over_c;
			pass_s1 <= pass_c;
			lrem_s1 <= lrem_c;
			eop_s1  <= end_of_packet;
			hits_s1 <= hits_flag;
			arem_s1 <= arem_c;
			orem_s1 <= orem_c;
			cnt_s1  <= cnt_c;
			rule_s1 <= write_rule;
		end
		if (s2_ready && v_s1)
			cmd_s2 <= cmd_c;
	end

endmodule

// ===== rtl/orie_back.sv =====
// Back end: owns the index table and rule list, executes table writes and
// expands overloaded lanes into result chunks. Depends on orie_pkg.
module orie_back import orie_pkg::*; #(
	parameter int PACK        = 4,
	parameter int INDEX_DEPTH = 1024,
	parameter int LIST_DEPTH  = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  orie_cmd_t cmd_head,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output logic      res_push,
	output orie_res_t res_data,
	input  logic      res_full
);

	localparam int IW = $clog2(INDEX_DEPTH);
	localparam int LW = $clog2(LIST_DEPTH);
	localparam int PW = $clog2(PACK + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_LOAD,
		ST_GATHER,
		ST_FLUSH
	} state_t;

	logic [ADDR_W+CNT_W-1:0]           idx_mem [INDEX_DEPTH];
	logic [RULE_W-1:0]                 rule_mem [LIST_DEPTH];
	logic [ADDR_W+CNT_W-1:0]           idx_rd_q;
	logic [RULE_W-1:0]                 rule_rd_q;

	state_t                            state_q;
	logic [LANE_SLOTS-1:0]             mask_q;
	logic [LANE_SLOTS-1:0][ADDR_W-1:0] idx_q;
	logic                              eop_q;
	logic                              last_q;
	orie_res_t                         hold_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  k_q;
	logic [PW-1:0]                     p_q;
	logic [LW-1:0]                     ptr_q;
	orie_lanes_t                       chunk_q;
	logic                              rd_v_q;
	logic [LANE_SEL_W-1:0]             rd_slot_q;

	logic                              idx_we;
	logic                              rule_we;
	logic                              idx_re;
	logic                              rule_re;
	logic [LANE_SEL_W-1:0]             sel;
	logic                              found;
	logic [LANE_SLOTS-1:0]             mask_next;
	logic [CNT_W-1:0]                  rd_cnt;
	logic [ADDR_W-1:0]                 rd_off;
	logic                              issue;
	logic                              chunk_done;
	logic                              flit_over;

	assign rd_cnt      = idx_rd_q[CNT_W-1:0];
	assign rd_off      = idx_rd_q[ADDR_W+CNT_W-1:CNT_W];
	assign issue       = (p_q < PW'(PACK)) && (k_q < cnt_q);
	assign chunk_done  = !issue && !rd_v_q;
	assign flit_over   = !cmd_empty && (cmd_head.op == OP_FLIT) && (cmd_head.over != '0);

	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int i = 0; i < LANE_SLOTS; i++) begin
			if (!found && mask_q[i]) begin
				sel   = LANE_SEL_W'(i);
				found = 1'b1;
			end
		end
		mask_next = mask_q & ~(LANE_SLOTS'(1) << sel);
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_data = hold_q;
		idx_we   = 1'b0;
		rule_we  = 1'b0;
		idx_re   = 1'b0;
		rule_re  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd_head.op)
						OP_FLIT: begin
							if (flit_over) begin
								cmd_pop = 1'b1;
							end else if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								res_data = '{lanes: cmd_head.pass, eop: cmd_head.eop,
									hits: cmd_head.hits, last: 1'b1};
							end
						end
						OP_IDX_WR: begin
							cmd_pop = 1'b1;
							idx_we  = 1'b1;
						end
						OP_RULE_WR: begin
							cmd_pop = 1'b1;
							rule_we = 1'b1;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			ST_LOOKUP: idx_re = 1'b1;
			ST_LOAD: begin
				if (rd_cnt == '0 && last_q && eop_q)
					res_push = !res_full;
			end
			ST_GATHER: begin
				rule_re = issue;
				if (chunk_done)
					res_push = !res_full;
			end
			ST_FLUSH: begin
				res_push      = !res_full;
				res_data.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (idx_we)
			idx_mem[cmd_head.addr[IW-1:0]] <= {cmd_head.offset, cmd_head.count};
		if (idx_re)
			idx_rd_q <= idx_mem[idx_q[sel][IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rule_we)
			rule_mem[cmd_head.addr[LW-1:0]] <= cmd_head.rule;
		if (rule_re)
			rule_rd_q <= rule_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mask_q    <= '0;
			idx_q     <= '0;
			eop_q     <= 1'b0;
			last_q    <= 1'b0;
			hold_q    <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			p_q       <= '0;
			ptr_q     <= '0;
			chunk_q   <= '0;
			rd_v_q    <= 1'b0;
			rd_slot_q <= '0;
		end else begin
			rd_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (flit_over) begin
						hold_q  <= '{lanes: cmd_head.pass, eop: 1'b0,
							hits: cmd_head.hits, last: 1'b0};
						mask_q  <= cmd_head.over;
						idx_q   <= cmd_head.idx;
						eop_q   <= cmd_head.eop;
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					mask_q  <= mask_next;
					last_q  <= (mask_next == '0);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (rd_cnt == '0) begin
						if (last_q && eop_q) begin
							if (!res_full) begin
								hold_q  <= '{lanes: '0, eop: 1'b1, hits: 1'b0, last: 1'b0};
								state_q <= ST_FLUSH;
							end
						end else begin
							state_q <= (mask_q != '0) ? ST_LOOKUP : ST_FLUSH;
						end
					end else begin
						cnt_q   <= rd_cnt;
						k_q     <= '0;
						p_q     <= '0;
						ptr_q   <= rd_off[LW-1:0];
						chunk_q <= '0;
						state_q <= ST_GATHER;
					end
				end
				ST_GATHER: begin
					if (rd_v_q)
						chunk_q[rd_slot_q] <= {1'b0, rule_rd_q} + LANE_W'(1);
					if (issue) begin
						rd_v_q    <= 1'b1;
						rd_slot_q <= LANE_SEL_W'(p_q);
						p_q       <= p_q + PW'(1);
						k_q       <= k_q + CNT_W'(1);
						ptr_q     <= (ptr_q == LW'(LIST_DEPTH - 1)) ? '0 : ptr_q + LW'(1);
					end else if (!rd_v_q && !res_full) begin
						hold_q <= '{lanes: chunk_q, eop: (last_q && k_q == cnt_q) ? eop_q : 1'b0,
							hits: 1'b1, last: 1'b0};
						if (k_q < cnt_q) begin
							p_q     <= '0;
							chunk_q <= '0;
						end else begin
							state_q <= (mask_q != '0) ? ST_LOOKUP : ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!res_full)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/overloaded_rule_id_expander_unit.sv =====
// Top level of the overloaded rule-id expander: front end, request queue, back end
// and result queue. Needs orie_pkg, orie_fifo, orie_front, orie_back, assert macros.
//
// Input side is a queue: present a request and raise push; it is taken on a
// rising edge with push high and full low. Opcode selects a flit, an index table
// write or a rule list write; opcode 3 is dropped. Result side is a queue too:
// while empty is low the oldest result sits on the out ports and is taken on an
// edge with pop high. last_of_run marks the final result of each flit.
// A flit with no overloaded lane passes both front stages and both queues.
// Results of an overloaded flit leave one step behind the sequencer, so its
// pass-through result waits until the first chunk, the empty end chunk or the close.
// Writes and flits without overloaded lanes run one per cycle while the back end
// is idle and the result queue has room. A flit with overloaded lanes holds the
// back end: it looks up the index entry of each overloaded lane, gathers its ids
// into chunks through the single rule list read port, then closes the run.
// Reset empties both queues and idles the sequencer; table contents are not
// cleared and must be written before use. A stalled receiver fills the result
// queue, then the back end holds, then the request queue and front fill and full
// rises; nothing is dropped.
`include "overloaded_rule_id_expander_unit_assert.svh"

module overloaded_rule_id_expander_unit import orie_pkg::*; #(
	parameter int LANES       = 4,
	parameter int PACK        = 4,
	parameter int INDEX_DEPTH = 1024,
	parameter int LIST_DEPTH  = 4096,
	parameter int MAX_COUNT   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [LANE_W-1:0] lane0,
	input  logic [LANE_W-1:0] lane1,
	input  logic [LANE_W-1:0] lane2,
	input  logic [LANE_W-1:0] lane3,
	input  logic              end_of_packet,
	input  logic              hits_flag,
	input  logic [ADDR_W-1:0] write_address,
	input  logic [ADDR_W-1:0] write_offset,
	input  logic [CNT_W-1:0]  write_count,
	input  logic [RULE_W-1:0] write_rule,
	output logic              empty,
	input  logic              pop,
	output logic [LANE_W-1:0] out_lane0,
	output logic [LANE_W-1:0] out_lane1,
	output logic [LANE_W-1:0] out_lane2,
	output logic [LANE_W-1:0] out_lane3,
	output logic              out_end_of_packet,
	output logic              out_has_hits,
	output logic              last_of_run
);

	orie_lanes_t lanes_in;
	logic        cmd_push;
	orie_cmd_t   cmd_in;
	logic        cmd_full;
	logic        cmd_empty;
	logic        cmd_pop;
	orie_cmd_t   cmd_head;
	logic        res_push;
	orie_res_t   res_in;
	logic        res_full;
	orie_res_t   res_head;

	assign lanes_in = {lane3, lane2, lane1, lane0};

	orie_front #(
		.LANES       (LANES),
		.INDEX_DEPTH (INDEX_DEPTH),
		.LIST_DEPTH  (LIST_DEPTH),
		.MAX_COUNT   (MAX_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.lanes         (lanes_in),
		.end_of_packet (end_of_packet),
		.hits_flag     (hits_flag),
		.write_address (write_address),
		.write_offset  (write_offset),
		.write_count   (write_count),
		.write_rule    (write_rule),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.cmd_full      (cmd_full)
	);

	orie_fifo #(.T(orie_cmd_t)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	orie_back #(
		.PACK        (PACK),
		.INDEX_DEPTH (INDEX_DEPTH),
		.LIST_DEPTH  (LIST_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_head  (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_in),
		.res_full  (res_full)
	);

	orie_fifo #(.T(orie_res_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign out_lane0         = res_head.lanes[0];
	assign out_lane1         = res_head.lanes[1];
	assign out_lane2         = res_head.lanes[2];
	assign out_lane3         = res_head.lanes[3];
	assign out_end_of_packet = res_head.eop;
	assign out_has_hits      = res_head.hits;
	assign last_of_run       = res_head.last;

	`ORIE_ASSERT_IMP(a_res_no_overflow, res_push, !res_full)
	`ORIE_ASSERT_IMP(a_cmd_no_overflow, cmd_push, !cmd_full)
	`ORIE_ASSERT_IMP(a_cmd_no_underflow, cmd_pop, !cmd_empty)
	`ORIE_ASSERT_NXT(a_cmd_visible, cmd_push && cmd_empty, !cmd_empty)

endmodule
